FILE: rtl/bti_pkg.sv
// Shared types and constants for the bilinear table interpolator.
// Table geometry, fixed-point widths, queue depths and the command word.
// No dependencies.
package bti_pkg;

	// table geometry
	localparam int COS_ENTRIES   = 32;
	localparam int ROUGH_ENTRIES = 32;
	localparam int CIW = (COS_ENTRIES > 1) ? $clog2(COS_ENTRIES) : 1;
	localparam int RIW = (ROUGH_ENTRIES > 1) ? $clog2(ROUGH_ENTRIES) : 1;
	// banks split the table by row and column parity
	localparam int CHW = (CIW > 1) ? CIW - 1 : 1;
	localparam int RHW = (RIW > 1) ? RIW - 1 : 1;
	localparam int BANK_AW    = CHW + RHW;
	localparam int BANK_DEPTH = 2 ** BANK_AW;
	localparam int NBANKS     = 4;

	// fixed point: Q1.16 values, 16-bit weights
	localparam int VW  = 17;
	localparam int FW  = 16;
	localparam int WIW = 5;   // width of the write index fields
	localparam logic [VW-1:0] ONE_Q16 = 17'h10000;

	// queues
	localparam int CMDQ_DEPTH = 4;
	localparam int CQ_AW      = $clog2(CMDQ_DEPTH);
	localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
	localparam int OUTQ_DEPTH = 8;
	localparam int OQ_AW      = $clog2(OUTQ_DEPTH);
	localparam int OQ_CW      = $clog2(OUTQ_DEPTH + 1);

	typedef enum logic {
		OP_WRITE  = 1'b0,
		OP_LOOKUP = 1'b1
	} op_t;

	// classified word handed from front to back
	typedef struct packed {
		op_t            op;
		logic           wr_ok;   // write address lies inside the table
		logic [CIW-1:0] c0;
		logic [CIW-1:0] c1;
		logic [RIW-1:0] r0;
		logic [RIW-1:0] r1;
		logic [FW-1:0]  fc;
		logic [FW-1:0]  fr;
		logic [VW-1:0]  value;
	} cmd_t;

endpackage

FILE: rtl/bti_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone, no package dependency.
module bti_ram #(
	parameter int W     = 17,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/bti_front.sv
// Front end: saturates coordinates, splits them into index and weight,
// and checks write addresses. Depends on bti_pkg.
module bti_front (
	input  logic                      op,
	input  logic [bti_pkg::WIW-1:0]   write_cos_index,
	input  logic [bti_pkg::WIW-1:0]   write_rough_index,
	input  logic [bti_pkg::VW-1:0]    write_value,
	input  logic [bti_pkg::VW-1:0]    cos_theta,
	input  logic [bti_pkg::VW-1:0]    rough_value,
	output bti_pkg::cmd_t             cmd
);

	localparam int CSW = bti_pkg::VW + bti_pkg::CIW;
	localparam int RSW = bti_pkg::VW + bti_pkg::RIW;

	logic [bti_pkg::VW-1:0]  c_sat, r_sat, v_sat;
	logic [CSW-1:0]          c_scaled;
	logic [RSW-1:0]          r_scaled;
	logic [bti_pkg::CIW-1:0] ci, ci_hi;
	logic [bti_pkg::RIW-1:0] ri, ri_hi;
	logic [8:0]              wc, wr;

	// saturate at 1.0
	assign c_sat = (cos_theta > bti_pkg::ONE_Q16) ? bti_pkg::ONE_Q16 : cos_theta;
	assign r_sat = (rough_value > bti_pkg::ONE_Q16) ? bti_pkg::ONE_Q16 : rough_value;
	assign v_sat = (write_value > bti_pkg::ONE_Q16) ? bti_pkg::ONE_Q16 : write_value;

	// scale by entries - 1, integer part is the index
	assign c_scaled = CSW'(c_sat) * CSW'(bti_pkg::COS_ENTRIES - 1);
	assign r_scaled = RSW'(r_sat) * RSW'(bti_pkg::ROUGH_ENTRIES - 1);
	assign ci = bti_pkg::CIW'(c_scaled >> bti_pkg::FW);
	assign ri = bti_pkg::RIW'(r_scaled >> bti_pkg::FW);

	// upper neighbor, clamped to the last entry
	assign ci_hi = (ci == bti_pkg::CIW'(bti_pkg::COS_ENTRIES - 1)) ? ci : ci + 1'b1;
	assign ri_hi = (ri == bti_pkg::RIW'(bti_pkg::ROUGH_ENTRIES - 1)) ? ri : ri + 1'b1;

	assign wc = 9'(write_cos_index);
	assign wr = 9'(write_rough_index);

	always_comb begin
		cmd       = '0;
		cmd.value = v_sat;
		cmd.fc    = c_scaled[bti_pkg::FW-1:0];
		cmd.fr    = r_scaled[bti_pkg::FW-1:0];
		if (op == bti_pkg::OP_LOOKUP) begin
			cmd.op = bti_pkg::OP_LOOKUP;
			cmd.c0 = ci;
			cmd.c1 = ci_hi;
			cmd.r0 = ri;
			cmd.r1 = ri_hi;
		end else begin
			// write: both neighbors point at the target entry
			cmd.op    = bti_pkg::OP_WRITE;
			cmd.wr_ok = (wc < 9'(bti_pkg::COS_ENTRIES)) && (wr < 9'(bti_pkg::ROUGH_ENTRIES));
			cmd.c0    = bti_pkg::CIW'(wc);
			cmd.c1    = bti_pkg::CIW'(wc);
			cmd.r0    = bti_pkg::RIW'(wr);
			cmd.r1    = bti_pkg::RIW'(wr);
		end
	end

endmodule

FILE: rtl/bti_cmd_queue.sv
// Short command queue between front and back ends.
// Depends on bti_pkg (cmd_t and depth).
module bti_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_en,
	input  bti_pkg::cmd_t din,
	output logic          full,
	input  logic          pop_en,
	output logic          not_empty,
	output bti_pkg::cmd_t dout
);

	bti_pkg::cmd_t                q_q [bti_pkg::CMDQ_DEPTH];
	logic [bti_pkg::CQ_AW-1:0]   wp_q, rp_q;
	logic [bti_pkg::CQ_CW-1:0]   cnt_q;

	assign full      = (cnt_q == bti_pkg::CQ_CW'(bti_pkg::CMDQ_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign dout      = q_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (push_en) begin
			q_q[wp_q] <= din;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push_en) begin
				wp_q <= (wp_q == bti_pkg::CQ_AW'(bti_pkg::CMDQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop_en) begin
				rp_q <= (rp_q == bti_pkg::CQ_AW'(bti_pkg::CMDQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			cnt_q <= cnt_q + bti_pkg::CQ_CW'(push_en) - bti_pkg::CQ_CW'(pop_en);
		end
	end

endmodule

FILE: rtl/bti_back.sv
// Back end: banked table, read and blend pipeline, result queue.
// Depends on bti_pkg and bti_ram.
module bti_back (
	input  logic                   clk,
	input  logic                   arst_n,
	input  bti_pkg::cmd_t          cmd,
	input  logic                   cmd_valid,
	output logic                   cmd_take,
	input  logic                   pop,
	output logic                   empty,
	output logic [bti_pkg::VW-1:0] albedo
);

	localparam int RW = 33;   // exact row value, Q.32
	localparam int AW = 49;   // exact blend, Q.48

	// issue control
	logic                      credit_ok, issue_lk, out_pop;
	logic [bti_pkg::OQ_CW-1:0] cnt_q;

	// bank ports
	logic [bti_pkg::BANK_AW-1:0] raddr [bti_pkg::NBANKS];
	logic                        we    [bti_pkg::NBANKS];
	logic [bti_pkg::VW-1:0]      rdata [bti_pkg::NBANKS];
	logic [1:0]                  wbank;

	// pipeline
	logic                   valid_s1, valid_s2, valid_s3;
	logic                   c0p_s1, c1p_s1, r0p_s1, r1p_s1;
	logic [bti_pkg::FW-1:0] fc_s1, fr_s1, fr_s2;
	logic [bti_pkg::VW-1:0] v00, v01, v10, v11, wfc, wfr;
	logic [RW-1:0]          row_a_s2, row_b_s2;
	logic [RW-1:0]          phi_s3, plo_s3;
	logic [AW-1:0]          acc;

	// result queue
	logic [bti_pkg::VW-1:0]    oq_q [bti_pkg::OUTQ_DEPTH];
	logic [bti_pkg::OQ_AW-1:0] owp_q, orp_q;
	logic [bti_pkg::OQ_CW-1:0] oc_q;

	// a lookup issues only when its result has a slot reserved
	assign credit_ok = (cnt_q < bti_pkg::OQ_CW'(bti_pkg::OUTQ_DEPTH));
	assign cmd_take  = cmd_valid && ((cmd.op == bti_pkg::OP_WRITE) || credit_ok);
	assign issue_lk  = cmd_take && (cmd.op == bti_pkg::OP_LOOKUP);
	assign out_pop   = pop && !empty;
	assign wbank     = {cmd.r0[0], cmd.c0[0]};

	// bank addressing: each bank takes whichever neighbor has its parity
	always_comb begin
		for (int b = 0; b < bti_pkg::NBANKS; b++) begin
			logic [bti_pkg::CIW-1:0] col;
			logic [bti_pkg::RIW-1:0] row;
			col = (cmd.c0[0] == b[0]) ? cmd.c0 : cmd.c1;
			row = (cmd.r0[0] == b[1]) ? cmd.r0 : cmd.r1;
			raddr[b] = {bti_pkg::RHW'(row >> 1), bti_pkg::CHW'(col >> 1)};
			we[b]    = cmd_take && (cmd.op == bti_pkg::OP_WRITE) && cmd.wr_ok &&
			           (wbank == 2'(b));
		end
	end

	for (genvar g = 0; g < bti_pkg::NBANKS; g++) begin : g_bank
		bti_ram #(
			.W     (bti_pkg::VW),
			.DEPTH (bti_pkg::BANK_DEPTH)
		) u_ram (
			.clk   (clk),
			.we    (we[g]),
			.waddr (raddr[g]),
			.wdata (cmd.value),
			.raddr (raddr[g]),
			.rdata (rdata[g])
		);
	end

	// stage 1 side info travels with the registered read
	always_ff @(posedge clk) begin
		c0p_s1 <= cmd.c0[0];
		c1p_s1 <= cmd.c1[0];
		r0p_s1 <= cmd.r0[0];
		r1p_s1 <= cmd.r1[0];
		fc_s1  <= cmd.fc;
		fr_s1  <= cmd.fr;
	end

	// pick the four corners from the banks
	assign v00 = rdata[{r0p_s1, c0p_s1}];
	assign v01 = rdata[{r0p_s1, c1p_s1}];
	assign v10 = rdata[{r1p_s1, c0p_s1}];
	assign v11 = rdata[{r1p_s1, c1p_s1}];
	assign wfc = bti_pkg::ONE_Q16 - bti_pkg::VW'(fc_s1);

	// stage 2: lerp along cosine in both rows
	always_ff @(posedge clk) begin
		row_a_s2 <= RW'(v00) * RW'(wfc) + RW'(v01) * RW'(fc_s1);
		row_b_s2 <= RW'(v10) * RW'(wfc) + RW'(v11) * RW'(fc_s1);
		fr_s2    <= fr_s1;
	end

	assign wfr = bti_pkg::ONE_Q16 - bti_pkg::VW'(fr_s2);

	// stage 3: row blend as high and low partial products
	always_ff @(posedge clk) begin
		phi_s3 <= RW'(row_a_s2[RW-1:bti_pkg::FW]) * RW'(wfr) +
		          RW'(row_b_s2[RW-1:bti_pkg::FW]) * RW'(fr_s2);
		plo_s3 <= RW'(row_a_s2[bti_pkg::FW-1:0]) * RW'(wfr) +
		          RW'(row_b_s2[bti_pkg::FW-1:0]) * RW'(fr_s2);
	end

	// final sum, one truncation to Q1.16
	assign acc = (AW'(phi_s3) << bti_pkg::FW) + AW'(plo_s3);

	// valid chain and credit count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= issue_lk;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			cnt_q    <= cnt_q + bti_pkg::OQ_CW'(issue_lk) - bti_pkg::OQ_CW'(out_pop);
		end
	end

	// result queue storage
	always_ff @(posedge clk) begin
		if (valid_s3) begin
			oq_q[owp_q] <= acc[AW-1:AW-bti_pkg::VW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q <= '0;
			orp_q <= '0;
			oc_q  <= '0;
		end else begin
			if (valid_s3) begin
				owp_q <= (owp_q == bti_pkg::OQ_AW'(bti_pkg::OUTQ_DEPTH - 1)) ? '0 : owp_q + 1'b1;
			end
			if (out_pop) begin
				orp_q <= (orp_q == bti_pkg::OQ_AW'(bti_pkg::OUTQ_DEPTH - 1)) ? '0 : orp_q + 1'b1;
			end
			oc_q <= oc_q + bti_pkg::OQ_CW'(valid_s3) - bti_pkg::OQ_CW'(out_pop);
		end
	end

	assign empty  = (oc_q == '0);
	assign albedo = oq_q[orp_q];

	// credits never exceed the result queue
	a_credit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= bti_pkg::OQ_CW'(bti_pkg::OUTQ_DEPTH))
		else $error("credit count above result queue depth");

	// a finishing lookup always finds room
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 |-> (oc_q < bti_pkg::OQ_CW'(bti_pkg::OUTQ_DEPTH)) || out_pop)
		else $error("result queue overflow");

	// queued words are a subset of reserved credits
	a_fill_le_credit: assert property (@(posedge clk) disable iff (!arst_n)
		oc_q <= cnt_q)
		else $error("result queue holds more words than issued");

	// an issued lookup passes valid_s1, valid_s2 and valid_s3 to reach the result queue
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		issue_lk |-> ##3 valid_s3)
		else $error("lookup lost in pipeline");

endmodule

FILE: rtl/bilinear_table_interpolator.sv
// Bilinear albedo table interpolator, top level.
// A lookup word reaches the result ports after it is accepted and passes through
// the command queue, banked RAM read, row lerp and row blend with final sum.
// Throughput: one word per cycle while a lookup finds a free result slot; four parity banks give the four corner reads.
// Reset clears queue pointers, counts and pipeline valids; table contents are not
// cleared, no entry may be read before it is written.
module bilinear_table_interpolator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	output logic                      full,
	input  logic                      op,
	input  logic [bti_pkg::WIW-1:0]   write_cos_index,
	input  logic [bti_pkg::WIW-1:0]   write_rough_index,
	input  logic [bti_pkg::VW-1:0]    write_value,
	input  logic [bti_pkg::VW-1:0]    cos_theta,
	input  logic [bti_pkg::VW-1:0]    rough_value,
	output logic                      empty,
	input  logic                      pop,
	output logic [bti_pkg::VW-1:0]    albedo
);

	bti_pkg::cmd_t front_cmd, queue_cmd;
	logic          queue_valid, queue_take, accept;

	assign accept = push && !full;

	// classify incoming words
	bti_front u_front (
		.op                (op),
		.write_cos_index   (write_cos_index),
		.write_rough_index (write_rough_index),
		.write_value       (write_value),
		.cos_theta         (cos_theta),
		.rough_value       (rough_value),
		.cmd               (front_cmd)
	);

	// decouple front from back
	bti_cmd_queue u_cmdq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_en   (accept),
		.din       (front_cmd),
		.full      (full),
		.pop_en    (queue_take),
		.not_empty (queue_valid),
		.dout      (queue_cmd)
	);

	// table access and blending
	bti_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (queue_cmd),
		.cmd_valid (queue_valid),
		.cmd_take  (queue_take),
		.pop       (pop),
		.empty     (empty),
		.albedo    (albedo)
	);

endmodule
